FILE: rtl/core/positional_voice_gain_macros.svh
// assertion macros shared by the rtl files
`ifndef POSITIONAL_VOICE_GAIN_MACROS_SVH
`define POSITIONAL_VOICE_GAIN_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define PVG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define PVG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/pvg_pkg.sv
package pvg_pkg;

    localparam int unsigned FALLOFF_RANGE = 1500;
    localparam int unsigned VOLUME_MAX    = 127;
    localparam int unsigned PERCENT_FULL  = 100;

    localparam int SAMPLE_W  = 9;
    localparam int COORD_W   = 24;
    localparam int VOL_W     = 7;
    localparam int MASTER_W  = 7;
    localparam int OFFSET_W  = 11;   // holds an offset below the falloff range
    localparam int SQ_W      = 24;   // sum of two squared offsets, padded to even
    localparam int ROOT_W    = SQ_W / 2;
    localparam int REM_W     = ROOT_W + 1;
    localparam int PROD_W    = 18;   // volume times a range difference
    localparam int ROOT_BITS_PER_STAGE = 4;
    localparam int ROOT_STAGES = ROOT_W / ROOT_BITS_PER_STAGE;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = COORD_W;

    localparam logic [CFG_IDX_W-1:0] CFG_MASTER_VOLUME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LISTENER_X    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LISTENER_Y    = 2'd2;

    localparam logic [MASTER_W-1:0] MASTER_RESET = MASTER_W'(PERCENT_FULL);

    // floor(x / 1500) = (x * RECIP_MUL) >> RECIP_SHIFT, exact for x below 2**PROD_W
    localparam int RECIP_W     = 18;
    localparam int RECIP_SHIFT = 28;
    localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_W'(178957);

    typedef struct packed {
        logic [SAMPLE_W-1:0]        sample_id;
        logic signed [COORD_W-1:0]  source_x;
        logic signed [COORD_W-1:0]  source_y;
        logic                       positional_flag;
        logic                       no_panning_flag;
    } t_req;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_out;
        logic [VOL_W-1:0]    volume;
        logic                play;
    } t_res;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_id;
        logic [VOL_W-1:0]    base;
        logic [OFFSET_W-1:0] adx;
        logic [OFFSET_W-1:0] ady;
        logic                far;
        logic                positional;
        logic                no_pan;
    } t_front;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_id;
        logic [VOL_W-1:0]    base;
        logic [SQ_W-1:0]     sum;
        logic [PROD_W-1:0]   pan_prod;
        logic                far;
        logic                positional;
        logic                no_pan;
    } t_square;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] val;
    } t_root;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_id;
        logic [VOL_W-1:0]    base;
        logic [VOL_W-1:0]    vol_p;
        logic                far;
        logic                positional;
        logic [SQ_W-1:0]     radicand;
        t_root               sqrt;
    } t_dist;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_id;
        logic [VOL_W-1:0]    base;
        logic                positional;
        logic                zero;
        logic [PROD_W-1:0]   prod;
    } t_scale;

    typedef logic [VOL_W-1:0] t_base_table [2**MASTER_W];

    function automatic t_base_table build_base_table();
        t_base_table tbl;
        int unsigned q;
        int unsigned v;
        for (int m = 0; m < 2**MASTER_W; m++) begin
            q = (m * 4096) / PERCENT_FULL;
            v = (q * VOLUME_MAX) >> 12;
            if (v > VOLUME_MAX) begin
                v = VOLUME_MAX;
            end
            tbl[m] = VOL_W'(v);
        end
        return tbl;
    endfunction

    localparam t_base_table BASE_TABLE = build_base_table();

    function automatic logic [VOL_W-1:0] div_range(input logic [PROD_W-1:0] x);
        logic [PROD_W+RECIP_W-1:0] p;
        p = (PROD_W+RECIP_W)'(x) * (PROD_W+RECIP_W)'(RECIP_MUL);
        return VOL_W'(p >> RECIP_SHIFT);
    endfunction

    // one restoring square root step: bring in two radicand bits, decide one root bit
    function automatic t_root root_step(input t_root s, input logic [1:0] pair);
        logic [REM_W+1:0] shifted;
        logic [REM_W+1:0] trial;
        t_root r;
        shifted = {s.rem, pair};
        trial   = {1'b0, s.val, 2'b01};
        if (shifted >= trial) begin
            r.rem = REM_W'(shifted - trial);
            r.val = {s.val[ROOT_W-2:0], 1'b1};
        end else begin
            r.rem = REM_W'(shifted);
            r.val = {s.val[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/pvg_stream_if.sv
interface pvg_stream_if #(parameter type t_data = logic);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/pvg_front.sv
`include "positional_voice_gain_macros.svh"

module pvg_front import pvg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    pvg_stream_if.sink            i_req,
    input  logic                  i_ready,
    output logic                  o_valid,
    output t_front                o_data
);

    logic [MASTER_W-1:0] r_master;
    logic [COORD_W-1:0]  r_listener_x;
    logic [COORD_W-1:0]  r_listener_y;
    logic                r_valid;
    t_front              r_data;
    t_front              n_data;

    logic [COORD_W:0] dx;
    logic [COORD_W:0] dy;
    logic [COORD_W:0] adx;
    logic [COORD_W:0] ady;

    always_comb begin
        dx  = {i_req.data.source_x[COORD_W-1], i_req.data.source_x}
            - {r_listener_x[COORD_W-1], r_listener_x};
        dy  = {i_req.data.source_y[COORD_W-1], i_req.data.source_y}
            - {r_listener_y[COORD_W-1], r_listener_y};
        adx = dx[COORD_W] ? (~dx + 1'b1) : dx;
        ady = dy[COORD_W] ? (~dy + 1'b1) : dy;

        n_data.sample_id  = i_req.data.sample_id;
        n_data.base       = BASE_TABLE[r_master];
        n_data.adx        = adx[OFFSET_W-1:0];
        n_data.ady        = ady[OFFSET_W-1:0];
        // either offset alone at the range puts the distance there too
        n_data.far        = (adx >= (COORD_W+1)'(FALLOFF_RANGE))
                         || (ady >= (COORD_W+1)'(FALLOFF_RANGE));
        n_data.positional = i_req.data.positional_flag;
        n_data.no_pan     = i_req.data.no_panning_flag;
    end

    assign i_req.ready = !r_valid || i_ready;
    assign o_valid     = r_valid;
    assign o_data      = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_master     <= MASTER_RESET;
            r_listener_x <= '0;
            r_listener_y <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MASTER_VOLUME: r_master     <= i_cfg_data[MASTER_W-1:0];
                    CFG_LISTENER_X:    r_listener_x <= i_cfg_data[COORD_W-1:0];
                    CFG_LISTENER_Y:    r_listener_y <= i_cfg_data[COORD_W-1:0];
                    default: ;
                endcase
            end
            if (i_req.ready) begin
                r_valid <= i_req.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_data <= n_data;
        end
    end

    `PVG_ASSERT_NEXT(a_front_holds, i_clk, i_rst_n, r_valid && !i_ready, r_valid && $stable(r_data), "front stage changed while stalled")

endmodule

FILE: rtl/core/pvg_dist.sv
`include "positional_voice_gain_macros.svh"

module pvg_dist import pvg_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_front  i_data,
    output logic    o_ready,
    output logic    o_valid,
    output t_dist   o_data,
    input  logic    i_ready
);

    localparam int LAST = ROOT_STAGES;

    // stage 0 squares, stages 1..ROOT_STAGES square root
    logic [LAST:0] r_valid;
    logic [LAST:0] adv;
    t_square       r_sq;
    t_square       n_sq;
    t_dist         r_dist [ROOT_STAGES];
    t_dist         n_dist [ROOT_STAGES];
    t_dist         seed;

    logic [SQ_W-1:0]   ax;
    logic [SQ_W-1:0]   ay;
    logic [PROD_W-1:0] off;

    function automatic t_dist root_steps(input t_dist d);
        t_dist r;
        r = d;
        for (int s = 0; s < ROOT_BITS_PER_STAGE; s++) begin
            r.sqrt     = root_step(r.sqrt, r.radicand[SQ_W-1 -: 2]);
            r.radicand = {r.radicand[SQ_W-3:0], 2'b00};
        end
        return r;
    endfunction

    always_comb begin
        ax  = SQ_W'(i_data.adx);
        ay  = SQ_W'(i_data.ady);
        off = PROD_W'(FALLOFF_RANGE) - PROD_W'(i_data.adx);

        n_sq.sample_id  = i_data.sample_id;
        n_sq.base       = i_data.base;
        n_sq.sum        = ax * ax + ay * ay;
        n_sq.pan_prod   = off * PROD_W'(i_data.base);
        n_sq.far        = i_data.far;
        n_sq.positional = i_data.positional;
        n_sq.no_pan     = i_data.no_pan;

        seed.sample_id  = r_sq.sample_id;
        seed.base       = r_sq.base;
        seed.vol_p      = r_sq.no_pan ? r_sq.base : div_range(r_sq.pan_prod);
        seed.far        = r_sq.far;
        seed.positional = r_sq.positional;
        seed.radicand   = r_sq.sum;
        seed.sqrt       = '0;

        n_dist[0] = root_steps(seed);
        for (int k = 1; k < ROOT_STAGES; k++) begin
            n_dist[k] = root_steps(r_dist[k-1]);
        end
    end

    always_comb begin
        adv[LAST] = !r_valid[LAST] || i_ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            adv[k] = !r_valid[k] || adv[k+1];
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_valid[LAST];
    assign o_data  = r_dist[ROOT_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (adv[0]) begin
                r_valid[0] <= i_valid;
            end
            for (int k = 1; k <= LAST; k++) begin
                if (adv[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0] && i_valid) begin
            r_sq <= n_sq;
        end
        for (int k = 0; k < ROOT_STAGES; k++) begin
            if (adv[k+1] && r_valid[k]) begin
                r_dist[k] <= n_dist[k];
            end
        end
    end

    `PVG_ASSERT_IMP(a_root_remainder, i_clk, i_rst_n, r_valid[LAST], r_dist[ROOT_STAGES-1].sqrt.rem <= {r_dist[ROOT_STAGES-1].sqrt.val, 1'b0}, "root remainder above twice the root")

endmodule

FILE: rtl/core/pvg_scale.sv
`include "positional_voice_gain_macros.svh"

module pvg_scale import pvg_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  t_dist        i_data,
    output logic         o_ready,
    pvg_stream_if.source o_res
);

    logic              r_valid_s;
    logic              r_valid_o;
    logic              adv_s;
    logic              adv_o;
    t_scale            r_s;
    t_scale            n_s;
    t_res              r_res;
    t_res              n_res;
    logic [PROD_W-1:0] off;
    logic [VOL_W-1:0]  vol;

    always_comb begin
        off = PROD_W'(FALLOFF_RANGE) - PROD_W'(i_data.sqrt.val);

        n_s.sample_id  = i_data.sample_id;
        n_s.base       = i_data.base;
        n_s.positional = i_data.positional;
        n_s.zero       = i_data.far
                      || (i_data.sqrt.val >= ROOT_W'(FALLOFF_RANGE));
        n_s.prod       = off * PROD_W'(i_data.vol_p);

        if (!r_s.positional) begin
            vol = r_s.base;
        end else if (r_s.zero) begin
            vol = '0;
        end else begin
            vol = div_range(r_s.prod);
        end
        n_res.sample_out = r_s.sample_id;
        n_res.volume     = vol;
        n_res.play       = (vol != '0);
    end

    assign adv_o       = !r_valid_o || o_res.ready;
    assign adv_s       = !r_valid_s || adv_o;
    assign o_ready     = adv_s;
    assign o_res.valid = r_valid_o;
    assign o_res.data  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_s <= 1'b0;
            r_valid_o <= 1'b0;
        end else begin
            if (adv_s) begin
                r_valid_s <= i_valid;
            end
            if (adv_o) begin
                r_valid_o <= r_valid_s;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_s && i_valid) begin
            r_s <= n_s;
        end
        if (adv_o && r_valid_s) begin
            r_res <= n_res;
        end
    end

    `PVG_ASSERT_IMP(a_play_matches_volume, i_clk, i_rst_n, o_res.valid, o_res.data.play == (o_res.data.volume != '0), "play flag disagrees with volume")
    `PVG_ASSERT_NEXT(a_far_is_silent, i_clk, i_rst_n, r_valid_s && adv_o && r_s.positional && r_s.zero, o_res.valid && o_res.data.volume == '0 && !o_res.data.play, "out of range item not silent")

endmodule

FILE: rtl/core/positional_voice_gain.sv
// a request passes through 7 register stages on its way to a result
// one request per cycle unless stalled; each stage holds one item and moves when the next frees
// the pace is set by the per-stage handshake, the root stages settle 4 bits each
// reset: synchronous, active low; clears all valid bits, master volume to 100, listener to 0,0
// no clearing pass; the block takes requests in the first cycle after reset

module positional_voice_gain import pvg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    pvg_stream_if.sink            i_req,
    pvg_stream_if.source          o_res
);

    // stage map
    //   front : offsets to the listener, range check, base volume from table
    //   dist  : squared offsets and pan product, then three root stages of
    //           four bits each; the pan division sits beside the first one
    //   scale : distance falloff product, then falloff division into the
    //           output register

    logic   front_valid;
    logic   front_ready;
    t_front front_data;

    logic   dist_valid;
    logic   dist_ready;
    t_dist  dist_data;

    pvg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (i_req),
        .i_ready     (front_ready),
        .o_valid     (front_valid),
        .o_data      (front_data)
    );

    // the root only matters below the range, so both offsets fit in
    // eleven bits and the radicand stays under twenty-four
    pvg_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .i_data  (front_data),
        .o_ready (front_ready),
        .o_valid (dist_valid),
        .o_data  (dist_data),
        .i_ready (dist_ready)
    );

    // the output register lets a new item come in while a result waits
    pvg_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dist_valid),
        .i_data  (dist_data),
        .o_ready (dist_ready),
        .o_res   (o_res)
    );

endmodule

FILE: dv/tb_positional_voice_gain.sv
`timescale 1ns / 1ps

module tb_positional_voice_gain;
    import pvg_pkg::*;

    localparam int IDLE_LIMIT = 2000;   // cycles with no item moving on either side
    localparam int DRAIN_TAIL = 12;     // a little over a request's trip from acceptance to its result

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pvg_stream_if #(.t_data(t_req)) req_if ();
    pvg_stream_if #(.t_data(t_res)) res_if ();

    positional_voice_gain dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (req_if),
        .o_res       (res_if)
    );

    // testbench copy of the gain registers, follows every write we issue
    logic [MASTER_W-1:0]       master_pct = MASTER_RESET;
    logic signed [COORD_W-1:0] lis_x      = '0;
    logic signed [COORD_W-1:0] lis_y      = '0;

    t_req req_backlog [$];     // requests waiting for the driver
    t_res gain_expected [$];   // predicted results, oldest first
    int   items_open  = 0;     // requests queued whose result has not been checked yet
    int   fail_count  = 0;
    int   idle_cycles = 0;
    int   src_gap     = 0;
    int   snk_gap     = 0;
    bit   src_steady  = 1'b0;  // no gaps on the request side for this phase
    bit   snk_steady  = 1'b0;  // no stalls on the result side for this phase
    t_res want_res;

    // floor square root, bit by bit from the top; n stays below 2**50
    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= n) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // volume for one request under the current gain registers
    function automatic t_res predict_gain(t_req r);
        longint unsigned q;
        longint unsigned vol;
        longint unsigned adx;
        longint unsigned ady;
        longint unsigned dist_root;
        longint          dx;
        longint          dy;
        t_res            res;
        q   = (64'(master_pct) * 4096) / PERCENT_FULL;
        vol = (q * VOLUME_MAX) >> 12;
        // master above one hundred saturates
        if (vol > VOLUME_MAX) begin
            vol = VOLUME_MAX;
        end
        if (r.positional_flag) begin
            dx   = longint'($signed(r.source_x)) - longint'(lis_x);
            dy   = longint'($signed(r.source_y)) - longint'(lis_y);
            adx  = (dx < 0) ? -dx : dx;
            ady  = (dy < 0) ? -dy : dy;
            dist_root = floor_sqrt(adx * adx + ady * ady);
            if (dist_root >= FALLOFF_RANGE) begin
                vol = 0;
            end else begin
                // horizontal offset term first, then the distance falloff
                if (!r.no_panning_flag) begin
                    vol = ((FALLOFF_RANGE - adx) * vol) / FALLOFF_RANGE;
                end
                vol = (vol * (FALLOFF_RANGE - dist_root)) / FALLOFF_RANGE;
            end
        end
        res.sample_out = r.sample_id;
        res.volume     = VOL_W'(vol);
        res.play       = (vol != 0);
        return res;
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp_coord(longint v);
        if (v > 64'sd8388607) begin
            return 24'sh7fffff;
        end
        if (v < -64'sd8388608) begin
            return 24'sh800000;
        end
        return COORD_W'(v);
    endfunction

    function automatic t_req make_req(int sid, longint sx, longint sy, bit pos, bit nopan);
        t_req r;
        r.sample_id       = SAMPLE_W'(sid);
        r.source_x        = clamp_coord(sx);
        r.source_y        = clamp_coord(sy);
        r.positional_flag = pos;
        r.no_panning_flag = nopan;
        return r;
    endfunction

    // mostly sources near the listener so the falloff arithmetic gets exercised,
    // some very close, some anywhere in the coordinate space
    function automatic t_req random_request();
        t_req   r;
        int     pick;
        int     span;
        longint dx;
        longint dy;
        pick = $urandom_range(0, 99);
        r.sample_id = SAMPLE_W'($urandom);
        if (pick < 15) begin
            r.source_x = COORD_W'($urandom);
            r.source_y = COORD_W'($urandom);
        end else begin
            span = (pick < 30) ? 40 : 1600;
            dx = longint'(int'($urandom_range(0, 2 * span)) - span);
            dy = longint'(int'($urandom_range(0, 2 * span)) - span);
            r.source_x = clamp_coord(longint'(lis_x) + dx);
            r.source_y = clamp_coord(longint'(lis_y) + dy);
        end
        r.positional_flag = ($urandom_range(0, 9) != 0);
        r.no_panning_flag = 1'($urandom_range(0, 1));
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(bit steady);
        int r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 88) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic queue_item(t_req r);
        req_backlog.push_back(r);
        items_open++;
    endtask

    // one register write per clock, write enable stays high across a burst
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_MASTER_VOLUME: master_pct = val[MASTER_W-1:0];
            CFG_LISTENER_X:    lis_x      = val;
            CFG_LISTENER_Y:    lis_y      = val;
            default: ;
        endcase
    endtask

    task automatic apply_setting(int master, int lx, int ly);
        write_reg(CFG_MASTER_VOLUME, CFG_DATA_W'(master));
        write_reg(CFG_LISTENER_X, CFG_DATA_W'(lx));
        write_reg(CFG_LISTENER_Y, CFG_DATA_W'(ly));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (items_open != 0) begin
            @(posedge i_clk);
        end
    endtask

    // a few edge items around the current listener, then random traffic
    task automatic run_phase(int n_random);
        longint lx;
        longint ly;
        lx = longint'(lis_x);
        ly = longint'(lis_y);
        src_steady = ($urandom_range(0, 3) == 0);
        snk_steady = ($urandom_range(0, 3) == 0);
        queue_item(make_req($urandom, lx, ly, 1'b1, 1'b0));
        queue_item(make_req($urandom, lx, ly, 1'b1, 1'b1));
        queue_item(make_req($urandom, lx + 1499, ly, 1'b1, 1'b0));
        queue_item(make_req($urandom, lx, ly - 1500, 1'b1, 1'b0));
        queue_item(make_req($urandom, lx - 1, ly + 1499, 1'b1, 1'b1));
        queue_item(make_req($urandom, lx + 5000, ly, 1'b0, 1'b0));
        repeat (n_random) begin
            queue_item(random_request());
        end
        wait_drained();
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // request side: one item per handshake, random gaps between items
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            req_if.data  <= '0;
            src_gap = 0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                gain_expected.push_back(predict_gain(req_if.data));
            end
            if (!req_if.valid || req_if.ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    req_if.valid <= 1'b0;
                end else if (req_backlog.size() > 0) begin
                    req_if.data  <= req_backlog.pop_front();
                    req_if.valid <= 1'b1;
                    src_gap = pick_gap(src_steady);
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // result side: compare against the oldest prediction, stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            snk_gap = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (gain_expected.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected result: sample %0d volume %0d play %0b",
                                 res_if.data.sample_out, res_if.data.volume,
                                 res_if.data.play);
                    end
                end else begin
                    want_res = gain_expected.pop_front();
                    items_open--;
                    if (want_res.sample_out !== res_if.data.sample_out ||
                        want_res.volume !== res_if.data.volume ||
                        want_res.play !== res_if.data.play) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch: expected sample %0d volume %0d play %0b, got %0d %0d %0b",
                                     want_res.sample_out, want_res.volume, want_res.play,
                                     res_if.data.sample_out, res_if.data.volume,
                                     res_if.data.play);
                        end
                    end
                end
                snk_gap = pick_gap(snk_steady);
            end
            if (snk_gap > 0) begin
                snk_gap--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // watchdog: nothing moving for too long means the block has hung
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int m;
        int lx;
        int ly;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = CFG_MASTER_VOLUME;
        i_cfg_data   = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: full master, listener at the origin
        queue_item(make_req(0, 0, 0, 1'b0, 1'b0));
        // flags without position: no-panning has no effect
        queue_item(make_req(511, 8388607, -8388608, 1'b0, 1'b1));
        // listener on the source, panning on and off
        queue_item(make_req(1, 0, 0, 1'b1, 1'b0));
        queue_item(make_req(2, 0, 0, 1'b1, 1'b1));
        // just inside and exactly at the falloff range
        queue_item(make_req(3, 1499, 0, 1'b1, 1'b0));
        queue_item(make_req(4, -1499, 0, 1'b1, 1'b1));
        queue_item(make_req(5, 1500, 0, 1'b1, 1'b1));
        queue_item(make_req(6, 900, 1200, 1'b1, 1'b0));
        queue_item(make_req(7, 899, 1200, 1'b1, 1'b0));
        queue_item(make_req(8, -1060, 1060, 1'b1, 1'b1));
        queue_item(make_req(15, 0, 1499, 1'b1, 1'b0));
        // coordinate extremes, offsets far beyond the range
        queue_item(make_req(9, 8388607, 8388607, 1'b1, 1'b0));
        queue_item(make_req(10, -8388608, -8388608, 1'b1, 1'b1));
        queue_item(make_req(16, -8388608, 8388607, 1'b1, 1'b0));
        // mid-range offsets with both panning settings
        queue_item(make_req(11, -750, 0, 1'b1, 1'b0));
        queue_item(make_req(12, 0, -1000, 1'b1, 1'b1));
        queue_item(make_req(13, 100, 100, 1'b1, 1'b0));
        queue_item(make_req(14, 100, 100, 1'b1, 1'b1));
        wait_drained();
        run_phase(150);

        // register extremes, master above one hundred among them
        apply_setting(0, 0, 0);
        run_phase(200);
        apply_setting(1, -8388608, 8388607);
        run_phase(200);
        apply_setting(127, 8388607, -8388608);
        run_phase(200);
        apply_setting(101, 12345, -6789);
        run_phase(200);
        apply_setting(100, -1, 1);
        run_phase(200);

        // random settings, listener sometimes near the origin
        repeat (4) begin
            m  = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 100) : $urandom_range(0, 127);
            lx = ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, 6000)) - 3000
                                             : int'($urandom_range(0, 16777215)) - 8388608;
            ly = ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, 6000)) - 3000
                                             : int'($urandom_range(0, 16777215)) - 8388608;
            apply_setting(m, lx, ly);
            run_phase(150);
        end

        repeat (DRAIN_TAIL) @(posedge i_clk);
        fail_count += gain_expected.size();
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
